[rtl/pfrp_pkg.sv]
// ----------------------------------------------------------------------------
// pfrp_pkg
// Shared types and codes of the page fault replacement policy core.
// ----------------------------------------------------------------------------
package pfrp_pkg;

  localparam int PAGE_IN_W  = 8;
  localparam int FRAME_OUT_W = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LFSR_W     = 16;
  localparam int DIV_CNT_W  = 4;

  // result action codes
  typedef enum logic [1:0] {
    ACT_FILL    = 2'd0,
    ACT_REPLACE = 2'd1,
    ACT_UPGRADE = 2'd2,
    ACT_RANGE   = 2'd3
  } action_e;

  // page status encodings
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_RW   = 2'd3;

  // policy codes (unused code behaves as fifo)
  localparam logic [1:0] POL_RANDOM = 2'd0;
  localparam logic [1:0] POL_FIFO   = 2'd1;
  localparam logic [1:0] POL_LEAST  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAGES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd3;

  // reset values
  localparam logic [1:0]        RST_POLICY = POL_FIFO;
  localparam logic [6:0]        RST_FRAMES = 7'd64;
  localparam logic [8:0]        RST_PAGES  = 9'd256;
  localparam logic [LFSR_W-1:0] RST_SEED   = 16'd44257;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_RANGE,
    OP_UPGRADE,
    OP_FILL,
    OP_FIFO,
    OP_RAND,
    OP_DIV,
    OP_INC,
    OP_SCAN,
    OP_SCAN_END,
    OP_OWN_RD,
    OP_EVICT,
    OP_MAP,
    OP_LOAD
  } dp_op_e;

  // datapath status seen by the controller
  typedef struct packed {
    logic       in_range;
    logic       resident;
    logic       has_free;
    logic [1:0] policy;
    logic       clr_last;
    logic       scan_last;
    logic       div_last;
    logic       out_free;
  } dp_status_t;

endpackage

[rtl/pfrp_ram.sv]
// ----------------------------------------------------------------------------
// pfrp_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pfrp_ctrl.sv]
// ----------------------------------------------------------------------------
// pfrp_ctrl
// Sequencer: walks one fault through lookup, victim choice and remap.
// ----------------------------------------------------------------------------
module pfrp_ctrl
  import pfrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t stat_i,
  output dp_op_e     op_o
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DIV,
    S_SCAN,
    S_SCAN_END,
    S_OWN,
    S_EVICT,
    S_MAP,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_CLEAR: begin
        op_o = OP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = OP_LATCH;
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (!stat_i.in_range) begin
          op_o    = OP_RANGE;
          state_d = S_DONE;
        end else if (stat_i.resident) begin
          op_o    = OP_UPGRADE;
          state_d = S_DONE;
        end else if (stat_i.has_free) begin
          op_o    = OP_FILL;
          state_d = S_DONE;
        end else if (stat_i.policy == POL_RANDOM) begin
          op_o    = OP_RAND;
          state_d = S_DIV;
        end else if (stat_i.policy == POL_LEAST) begin
          op_o    = OP_INC;
          state_d = S_SCAN;
        end else begin
          op_o    = OP_FIFO;
          state_d = S_OWN;
        end
      end
      S_DIV: begin
        op_o = OP_DIV;
        if (stat_i.div_last) state_d = S_OWN;
      end
      S_SCAN: begin
        op_o = OP_SCAN;
        if (stat_i.scan_last) state_d = S_SCAN_END;
      end
      S_SCAN_END: begin
        op_o    = OP_SCAN_END;
        state_d = S_OWN;
      end
      S_OWN: begin
        op_o    = OP_OWN_RD;
        state_d = S_EVICT;
      end
      S_EVICT: begin
        op_o    = OP_EVICT;
        state_d = S_MAP;
      end
      S_MAP: begin
        op_o    = OP_MAP;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          op_o    = OP_LOAD;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[rtl/pfrp_dp.sv]
// ----------------------------------------------------------------------------
// pfrp_dp
// Datapath: config registers, page table, owner and count memories,
// victim selection units and the result register.
// ----------------------------------------------------------------------------
module pfrp_dp
  import pfrp_pkg::*;
#(
  parameter int MAX_PAGES   = 256,
  parameter int MAX_FRAMES  = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_op_e                  op_i,
  output dp_status_t              stat_o,
  input  logic [PAGE_IN_W-1:0]    fault_page_i,
  input  logic                    cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                    out_stall_i,
  output logic                    out_valid_o,
  output logic [1:0]              action_o,
  output logic [FRAME_OUT_W-1:0]  frame_o,
  output logic [PAGE_IN_W-1:0]    victim_page_o,
  output logic                    victim_valid_o
);

  localparam int PW  = $clog2(MAX_PAGES);
  localparam int FW  = $clog2(MAX_FRAMES);
  localparam int FCW = $clog2(MAX_FRAMES + 1);
  localparam int PCW = $clog2(MAX_PAGES + 1);
  localparam int EFW = (FCW > 7) ? FCW : 7;
  localparam int EPW = (PCW > 9) ? PCW : 9;
  localparam int PIW = (PW > PAGE_IN_W) ? PW : PAGE_IN_W;
  localparam int CLN = (MAX_PAGES > MAX_FRAMES) ? MAX_PAGES : MAX_FRAMES;
  localparam int CLW = $clog2(CLN);
  localparam int RW  = EFW + 1;
  localparam int PTW = FW + 2;

  // config
  logic [1:0]        policy_q;
  logic [6:0]        frame_count_q;
  logic [8:0]        page_count_q;
  logic [LFSR_W-1:0] lfsr_q;

  // per-fault state
  logic [PIW-1:0]         page_q;
  logic [FCW-1:0]         filled_q;
  logic [FW-1:0]          fifo_q;
  logic [FW-1:0]          vframe_q;
  logic [PW-1:0]          victim_q;
  logic [CLW-1:0]         clr_q;
  logic [PW-1:0]          scan_q;
  logic                   scan_vld_q;
  logic                   found_q;
  logic [COUNT_WIDTH-1:0] best_q;
  logic [LFSR_W-1:0]      div_q;
  logic [RW-1:0]          rem_q;
  logic [DIV_CNT_W-1:0]   dcnt_q;

  // staged and output results
  action_e        res_action_q, out_action_q;
  logic [FW-1:0]  res_frame_q, out_frame_q;
  logic [PW-1:0]  res_victim_q, out_victim_q;
  logic           res_vvalid_q, out_vvalid_q;
  logic           out_valid_q;

  // memory ports
  logic                   pt_we, cnt_we, own_we;
  logic [PW-1:0]          pt_waddr, rd_addr;
  logic [PTW-1:0]         pt_wdata, pt_rdata;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
  logic [FW-1:0]          own_waddr;
  logic [PW-1:0]          own_wdata, own_rdata;

  logic [EFW-1:0]         fc_ext, eff_frames, fifo_cur;
  logic [EPW-1:0]         pc_ext, eff_pages;
  logic [FW-1:0]          pt_frame;
  logic [1:0]             pt_stat;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   lfsr_fb;
  logic [LFSR_W-1:0]      lfsr_nx;
  logic [RW-1:0]          rem_try, rem_nx;
  logic [CLW:0]           clr_ext;

  // saturate config into legal ranges
  assign fc_ext     = EFW'(frame_count_q);
  assign eff_frames = (fc_ext < EFW'(3)) ? EFW'(3) :
                      (fc_ext > EFW'(MAX_FRAMES)) ? EFW'(MAX_FRAMES) : fc_ext;
  assign pc_ext     = EPW'(page_count_q);
  assign eff_pages  = (pc_ext < EPW'(1)) ? EPW'(1) :
                      (pc_ext > EPW'(MAX_PAGES)) ? EPW'(MAX_PAGES) : pc_ext;

  assign pt_frame = pt_rdata[PTW-1:2];
  assign pt_stat  = pt_rdata[1:0];
  assign cnt_inc  = (cnt_rdata == {COUNT_WIDTH{1'b1}}) ? cnt_rdata
                                                       : cnt_rdata + 1'b1;

  // Fibonacci LFSR, taps 16,14,13,11
  assign lfsr_fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
  assign lfsr_nx = {lfsr_fb, lfsr_q[LFSR_W-1:1]};

  // restoring remainder, one dividend bit per step
  assign rem_try = {rem_q[RW-2:0], div_q[LFSR_W-1]};
  assign rem_nx  = (rem_try >= RW'(eff_frames)) ? rem_try - RW'(eff_frames) : rem_try;

  assign fifo_cur = (EFW'(fifo_q) >= eff_frames) ? '0 : EFW'(fifo_q);
  assign clr_ext  = (CLW + 1)'(clr_q);

  assign rd_addr = (op_i == OP_LATCH) ? PW'(fault_page_i) :
                   (op_i == OP_SCAN)  ? scan_q : page_q[PW-1:0];

  always_comb begin
    pt_we     = 1'b0;
    pt_waddr  = page_q[PW-1:0];
    pt_wdata  = '0;
    cnt_we    = 1'b0;
    cnt_wdata = cnt_inc;
    own_we    = 1'b0;
    own_waddr = vframe_q;
    own_wdata = page_q[PW-1:0];
    case (op_i)
      OP_CLEAR: begin
        pt_we     = (clr_ext < (CLW + 1)'(MAX_PAGES));
        pt_waddr  = PW'(clr_q);
        cnt_we    = pt_we;
        cnt_wdata = '0;
        own_we    = (clr_ext < (CLW + 1)'(MAX_FRAMES));
        own_waddr = FW'(clr_q);
        own_wdata = '0;
      end
      OP_UPGRADE: begin
        pt_we    = 1'b1;
        pt_wdata = {pt_frame, ST_RW};
      end
      OP_FILL: begin
        pt_we     = 1'b1;
        pt_wdata  = {FW'(filled_q), ST_READ};
        own_we    = 1'b1;
        own_waddr = FW'(filled_q);
      end
      OP_INC: cnt_we = 1'b1;
      OP_EVICT: begin
        pt_we    = 1'b1;
        pt_waddr = own_rdata;
      end
      OP_MAP: begin
        pt_we    = 1'b1;
        pt_wdata = {vframe_q, ST_READ};
        own_we   = 1'b1;
      end
      default: ;
    endcase
  end

  pfrp_ram #(.WIDTH(PTW), .DEPTH(MAX_PAGES), .AW(PW)) u_pt_ram (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .raddr_i (rd_addr),
    .rdata_o (pt_rdata)
  );

  pfrp_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_PAGES), .AW(PW)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (pt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (rd_addr),
    .rdata_o (cnt_rdata)
  );

  pfrp_ram #(.WIDTH(PW), .DEPTH(MAX_FRAMES), .AW(FW)) u_own_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .raddr_i (vframe_q),
    .rdata_o (own_rdata)
  );

  // clear sweep addresses both page-indexed memories with one counter; the
  // count RAM shares the page table write address (count writes only happen
  // while clearing and at OP_INC, at page_q).

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q      <= RST_POLICY;
      frame_count_q <= RST_FRAMES;
      page_count_q  <= RST_PAGES;
      lfsr_q        <= RST_SEED;
      filled_q      <= '0;
      fifo_q        <= '0;
      clr_q         <= '0;
      scan_vld_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_POLICY: policy_q      <= cfg_data_i[1:0];
          REG_FRAMES: frame_count_q <= cfg_data_i[6:0];
          REG_PAGES:  page_count_q  <= cfg_data_i[8:0];
          REG_SEED:   lfsr_q <= (cfg_data_i == '0) ? LFSR_W'(1) : cfg_data_i;
          default: ;
        endcase
      end
      scan_vld_q <= (op_i == OP_SCAN);
      case (op_i)
        OP_CLEAR: clr_q    <= clr_q + 1'b1;
        OP_FILL:  filled_q <= filled_q + 1'b1;
        OP_FIFO:  fifo_q   <= (fifo_cur + EFW'(1) >= eff_frames) ? '0
                                                                  : FW'(fifo_cur + EFW'(1));
        OP_RAND:  lfsr_q   <= lfsr_nx;
        default: ;
      endcase
      if (op_i == OP_LOAD) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LATCH: page_q <= PIW'(fault_page_i);
      OP_RANGE: begin
        res_action_q <= ACT_RANGE;
        res_frame_q  <= '0;
        res_victim_q <= '0;
        res_vvalid_q <= 1'b0;
      end
      OP_UPGRADE: begin
        res_action_q <= ACT_UPGRADE;
        res_frame_q  <= pt_frame;
        res_victim_q <= '0;
        res_vvalid_q <= 1'b0;
      end
      OP_FILL: begin
        res_action_q <= ACT_FILL;
        res_frame_q  <= FW'(filled_q);
        res_victim_q <= '0;
        res_vvalid_q <= 1'b0;
      end
      OP_FIFO: vframe_q <= FW'(fifo_cur);
      OP_RAND: begin
        div_q  <= lfsr_nx;
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      OP_DIV: begin
        div_q  <= {div_q[LFSR_W-2:0], 1'b0};
        rem_q  <= rem_nx;
        dcnt_q <= dcnt_q + 1'b1;
        if (dcnt_q == {DIV_CNT_W{1'b1}}) vframe_q <= FW'(rem_nx);
      end
      OP_INC: begin
        scan_q   <= '0;
        found_q  <= 1'b0;
        best_q   <= '0;
        vframe_q <= '0;
      end
      OP_SCAN: scan_q <= scan_q + 1'b1;
      OP_EVICT: victim_q <= own_rdata;
      OP_MAP: begin
        res_action_q <= ACT_REPLACE;
        res_frame_q  <= vframe_q;
        res_victim_q <= victim_q;
        res_vvalid_q <= 1'b1;
      end
      OP_LOAD: begin
        out_action_q <= res_action_q;
        out_frame_q  <= res_frame_q;
        out_victim_q <= res_victim_q;
        out_vvalid_q <= res_vvalid_q;
      end
      default: ;
    endcase
    // least-count compare, one page behind the read address
    if (scan_vld_q && pt_stat != ST_NONE && (!found_q || cnt_rdata < best_q)) begin
      found_q  <= 1'b1;
      best_q   <= cnt_rdata;
      vframe_q <= pt_frame;
    end
  end

  assign stat_o.in_range  = (EPW'(page_q) < eff_pages);
  assign stat_o.resident  = (pt_stat != ST_NONE);
  assign stat_o.has_free  = (EFW'(filled_q) < eff_frames);
  assign stat_o.policy    = policy_q;
  assign stat_o.clr_last  = (clr_q == CLW'(CLN - 1));
  assign stat_o.scan_last = (scan_q == PW'(MAX_PAGES - 1));
  assign stat_o.div_last  = (dcnt_q == {DIV_CNT_W{1'b1}});
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign action_o       = out_action_q;
  assign frame_o        = FRAME_OUT_W'(out_frame_q);
  assign victim_page_o  = PAGE_IN_W'(out_victim_q);
  assign victim_valid_o = out_vvalid_q;

endmodule

[rtl/page_fault_replacement_policy_core.sv]
// ----------------------------------------------------------------------------
// page_fault_replacement_policy_core
// Page fault handler: maps faulting pages into frames, evicting a victim by
// random, fifo or least-faulted policy when all frames are used.
// ----------------------------------------------------------------------------
//  channel | handshake             | word
//  --------+-----------------------+------------------------------------------
//  in      | in_valid_i/in_stall_o | fault_page_i
//  out     | out_valid_o/out_stall_i | action_o, frame_o, victim_page_o,
//          |                       | victim_valid_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  Steps per word: range fault, upgrade or fill finish at the lookup; each
//    replace adds owner read, evict and map, random replace first runs the
//    16-step remainder unit and least-faulted replace first runs the
//    page-by-page count scan through the page table and count memories.
//  One word in flight; the next is taken once the result sits in the output
//    register, so a stalled output costs nothing until the following result.
//  Reset: a clearing sweep over max(MAX_PAGES, MAX_FRAMES) addresses
//    zeroes the memories; no word is taken meanwhile, config is.
//  cfg_ready_o is always high; write config only while idle.
// ----------------------------------------------------------------------------
module page_fault_replacement_policy_core
  import pfrp_pkg::*;
#(
  parameter int MAX_PAGES   = 256,
  parameter int MAX_FRAMES  = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [PAGE_IN_W-1:0]   fault_page_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             action_o,
  output logic [FRAME_OUT_W-1:0] frame_o,
  output logic [PAGE_IN_W-1:0]   victim_page_o,
  output logic                   victim_valid_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  dp_op_e     op;
  dp_status_t stat;

  // controller: one state per step of the fault flow
  pfrp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .op_o       (op)
  );

  // datapath: memories, victim units, result register
  pfrp_dp #(
    .MAX_PAGES   (MAX_PAGES),
    .MAX_FRAMES  (MAX_FRAMES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .stat_o         (stat),
    .fault_page_i   (fault_page_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .action_o       (action_o),
    .frame_o        (frame_o),
    .victim_page_o  (victim_page_o),
    .victim_valid_o (victim_valid_o)
  );

  // config registers take a write in any cycle
  assign cfg_ready_o = 1'b1;

endmodule

[rtl/pfrp_checker.sv]
// ----------------------------------------------------------------------------
// pfrp_checker
// Port-level checks of the page fault replacement policy core.
// ----------------------------------------------------------------------------
module pfrp_checker
  import pfrp_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [1:0]             action_o,
  input logic [FRAME_OUT_W-1:0] frame_o,
  input logic [PAGE_IN_W-1:0]   victim_page_o,
  input logic                   victim_valid_o
);

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o) &&
    $stable(frame_o) && $stable(victim_page_o) && $stable(victim_valid_o))
    else $error("stalled result changed");

  // one fault at a time: busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a fault is in progress");

  // a victim is reported exactly on replace
  a_victim_on_replace: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (victim_valid_o == (action_o == ACT_REPLACE)))
    else $error("victim flag disagrees with action");

  // range faults carry no frame or victim
  a_range_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == ACT_RANGE |-> frame_o == '0 && victim_page_o == '0)
    else $error("range fault with nonzero fields");

endmodule

bind page_fault_replacement_policy_core pfrp_checker u_pfrp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .action_o       (action_o),
  .frame_o        (frame_o),
  .victim_page_o  (victim_page_o),
  .victim_valid_o (victim_valid_o)
);

[test/page_fault_replacement_policy_core_tb.sv]
// ----------------------------------------------------------------------------
// page_fault_replacement_policy_core_tb
// Self-checking bench: a behavioral copy of the fault handler predicts
// every result word. Covers fill, upgrade, range faults and all three
// replacement policies, with register saturation, zero seed and
// back-pressure. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module page_fault_replacement_policy_core_tb;
  import pfrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPAGES     = 256;
  localparam int NFRAMES    = 64;
  localparam int CNT_MAX    = 65535;
  localparam int IDLE_LIMIT = 5000;   // cycles without any accepted word
  localparam logic [1:0] POL_SPARE = 2'd3;  // unused code, acts as fifo

  typedef struct packed {
    action_e    act;
    logic [5:0] frame;
    logic [7:0] victim;
    logic       vvalid;
  } fault_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [PAGE_IN_W-1:0] fault_page_i = '0;
  logic out_stall_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_stall_o, out_valid_o, cfg_ready_o, victim_valid_o;
  logic [1:0] action_o;
  logic [FRAME_OUT_W-1:0] frame_o;
  logic [PAGE_IN_W-1:0] victim_page_o;

  page_fault_replacement_policy_core DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---- handler model state ----
  logic [1:0]  pol_reg;
  logic [6:0]  frames_reg;
  logic [8:0]  pages_reg;
  logic [15:0] lfsr_q;
  logic [5:0]  page_frame [NPAGES];
  logic [1:0]  page_state [NPAGES];
  logic [7:0]  frame_owner [NFRAMES];
  int          frames_used;
  int          fifo_ptr;
  int          fault_cnt [NPAGES];

  fault_word_t pending_words [$];
  int errors = 0;
  int stall_pct = 0;
  int idle_pct = 0;
  int hold_off = 0;   // forced receiver stall, counted down by the receiver

  function automatic int live_frames();
    int f;
    f = frames_reg;
    if (f < 3) f = 3;
    if (f > NFRAMES) f = NFRAMES;
    return f;
  endfunction

  function automatic int live_pages();
    int p;
    p = pages_reg;
    if (p < 1) p = 1;
    if (p > NPAGES) p = NPAGES;
    return p;
  endfunction

  task automatic clear_handler();
    pol_reg = RST_POLICY;
    frames_reg = RST_FRAMES;
    pages_reg = RST_PAGES;
    lfsr_q = RST_SEED;
    for (int i = 0; i < NPAGES; i++) begin
      page_frame[i] = '0;
      page_state[i] = ST_NONE;
      fault_cnt[i] = 0;
    end
    for (int i = 0; i < NFRAMES; i++) frame_owner[i] = '0;
    frames_used = 0;
    fifo_ptr = 0;
  endtask

  // Work out what the handler does for one faulting page.
  function automatic fault_word_t handle_fault(int page);
    fault_word_t w;
    int frames, fr, best;
    bit found;
    logic b;
    frames = live_frames();
    w = '{act: ACT_RANGE, frame: '0, victim: '0, vvalid: 1'b0};
    if (page >= live_pages()) return w;
    if (page_state[page] != ST_NONE) begin
      w.act = ACT_UPGRADE;
      page_state[page] = ST_RW;
      w.frame = page_frame[page];
      return w;
    end
    if (frames_used < frames) begin
      w.act = ACT_FILL;
      fr = frames_used;
      frames_used++;
    end else begin
      w.act = ACT_REPLACE;
      if (pol_reg == POL_RANDOM) begin
        b = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
        lfsr_q = {b, lfsr_q[15:1]};
        fr = int'(lfsr_q) % frames;
      end else if (pol_reg == POL_LEAST) begin
        if (fault_cnt[page] < CNT_MAX) fault_cnt[page]++;
        fr = 0;
        found = 0;
        best = 0;
        for (int i = 0; i < NPAGES; i++)
          if (page_state[i] != ST_NONE && (!found || fault_cnt[i] < best)) begin
            found = 1;
            best = fault_cnt[i];
            fr = page_frame[i];
          end
      end else begin
        if (fifo_ptr >= frames) fifo_ptr = 0;
        fr = fifo_ptr;
        fifo_ptr = (fifo_ptr + 1 >= frames) ? 0 : fifo_ptr + 1;
      end
      w.victim = frame_owner[fr];
      w.vvalid = 1'b1;
      page_state[w.victim] = ST_NONE;
      page_frame[w.victim] = '0;
    end
    w.frame = fr[5:0];
    page_frame[page] = fr[5:0];
    page_state[page] = ST_READ;
    frame_owner[fr] = page[7:0];
    return w;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // ---- receiver: random stall plus a forced hold-off ----
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---- result checker ----
  always @(posedge clk_i) begin
    fault_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        report("unexpected word, action", 16'(action_o), 16'hFFFF);
      end else begin
        w = pending_words.pop_front();
        if (action_o != w.act) report("action", 16'(action_o), 16'(w.act));
        if (frame_o != w.frame) report("frame", 16'(frame_o), 16'(w.frame));
        if (victim_page_o != w.victim)
          report("victim_page", 16'(victim_page_o), 16'(w.victim));
        if (victim_valid_o != w.vvalid)
          report("victim_valid", 16'(victim_valid_o), 16'(w.vvalid));
      end
    end
  end

  // ---- watchdog: counts cycles in which no word moves ----
  int quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet <= 0;
    else if (quiet >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  // ---- sender side; all calls start and end at a rising edge ----
  task automatic send_fault(int page);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    fault_page_i <= page[7:0];
    do @(posedge clk_i); while (in_stall_o);
    pending_words.push_back(handle_fault(page));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_POLICY: pol_reg = data[1:0];
      REG_FRAMES: frames_reg = data[6:0];
      REG_PAGES:  pages_reg = data[8:0];
      default: begin
        lfsr_q = (data == 16'd0) ? 16'd1 : data;
      end
    endcase
  endtask

  task automatic setup(logic [1:0] pol, logic [15:0] fr, logic [15:0] pg,
                       logic [15:0] seed);
    drain();
    write_reg(REG_POLICY, 16'(pol));
    write_reg(REG_FRAMES, fr);
    write_reg(REG_PAGES, pg);
    write_reg(REG_SEED, seed);
  endtask

  // Mostly a working set a bit wider than the frames, so replacement fires.
  task automatic random_run(int n, int span);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 85) send_fault($urandom_range(span - 1));
      else send_fault($urandom_range(255));
      if (k % 60 == 59) begin
        case ($urandom_range(3))
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 80; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 80; end
          default: begin idle_pct = 24; stall_pct = 24; end
        endcase
      end
    end
  endtask

  task automatic test_directed();
    // defaults: fifo, 64 frames, 256 pages
    send_fault(0);      // fill
    send_fault(0);      // read -> read-write
    send_fault(0);      // already read-write
    send_fault(255);    // top page
    setup(POL_FIFO, 3, 8, 16'hFFFF);
    send_fault(8);      // out of range
    send_fault(255);
    for (int p = 1; p < 8; p++) send_fault(p);  // fill up, fifo evictions
    send_fault(1);
    setup(POL_RANDOM, 3, 8, 16'd0);   // zero seed loads one
    for (int p = 0; p < 5; p++) send_fault(p);
    setup(POL_LEAST, 3, 8, 16'd1);
    for (int p = 0; p < 5; p++) send_fault(p);
    setup(POL_SPARE, 16'h7F, 16'd0, 16'd2);  // saturation both ways
    send_fault(0);
    send_fault(1);
    setup(POL_FIFO, 16'd0, 16'h1FF, 16'd3);
    send_fault(200);
  endtask

  task automatic test_fifo();
    setup(POL_FIFO, 8, 256, 16'd5);
    random_run(450, 14);
    setup(POL_FIFO, 64, 256, 16'd5);
    random_run(300, 96);
  endtask

  task automatic test_random();
    setup(POL_RANDOM, 5, 100, 16'($urandom_range(65535, 1)));
    random_run(300, 9);
    setup(POL_RANDOM, 64, 256, 16'($urandom_range(65535, 1)));
    random_run(200, 80);
  endtask

  task automatic test_least();
    setup(POL_LEAST, 3, 12, 16'd7);
    random_run(220, 8);
    setup(POL_LEAST, 64, 256, 16'd7);
    random_run(100, 100);
  endtask

  task automatic test_odd_settings();
    setup(POL_SPARE, 2, 1, 16'd0);
    random_run(100, 4);
    setup(POL_RANDOM, 127, 511, 16'h8000);
    random_run(150, 90);
  endtask

  task automatic test_backpressure();
    setup(POL_FIFO, 4, 16, 16'd9);
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 600;
    for (int k = 0; k < 12; k++) send_fault($urandom_range(15));
    random_run(60, 16);
  endtask

  initial begin
    clear_handler();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fifo();
    test_random();
    test_least();
    test_odd_settings();
    test_backpressure();
    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
